// File: design/u8dec_pkg.sv
// Shared types and constants for the UTF-8 decoder.
// Used by u8dec_front, u8dec_queue, u8dec_back and the top level.
package u8dec_pkg;

    // Output buffer size limits (units, terminator included)
    localparam int MAX_CAPACITY = 256;
    localparam logic [8:0] CAP_RESET = 9'd192;
    localparam logic MODE_RESET = 1'b1;

    // Configuration register indexes
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_SIXTEEN_BIT_MODE = 1'b1;

    // Byte classification constants
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG = 8'h80;
    localparam logic [7:0] LEAD_MIN = 8'hC2;
    localparam logic [7:0] LEAD_MAX = 8'hF4;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;

    // UTF-16 surrogate constants
    localparam logic [20:0] BMP_MAX = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [20:0] HI_SURR = 21'h00D800;
    localparam logic [20:0] LO_SURR = 21'h00DC00;

    // Per-item result bundle and the queue between front and back
    localparam int UNITS_PER_ITEM = 4;
    localparam int UNIT_W = 21;
    localparam int QDEPTH = 4;  // power of two
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0] last_idx;                            // unit count minus one
        logic [UNITS_PER_ITEM-1:0][UNIT_W-1:0] unit;
        logic [UNITS_PER_ITEM-1:0] last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic valid;
    } t_qstat;

endpackage

// File: design/u8dec_front.sv
// Front end: takes one byte per item, tracks the held sequence and buffer fill,
// and turns each item into a bundle of up to four output units. Uses u8dec_pkg.
module u8dec_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [7:0]         i_in_byte,
    output logic               o_in_stall,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  u8dec_pkg::t_qstat  i_qstat,
    output logic               o_push,
    output u8dec_pkg::t_entry  o_entry
);

    // Configuration and string state
    logic [8:0] r_cap;
    logic       r_mode;
    logic [7:0] r_hb0, r_hb1, r_hb2;
    logic [1:0] r_hc, r_ne;
    logic [8:0] r_w;
    logic       r_full;

    logic [7:0] n_hb0, n_hb1, n_hb2;
    logic [1:0] n_hc, n_ne;
    logic [8:0] n_w;
    logic       n_full;

    logic       w_accept;
    logic       w_zero, w_cont, w_lead;
    logic [1:0] w_need;
    logic [5:0] w_lead_bits;
    logic [20:0] w_code, w_cm, w_hi, w_lo;
    logic [8:0] w_cap_eff;

    logic [u8dec_pkg::UNITS_PER_ITEM-1:0][u8dec_pkg::UNIT_W-1:0] v_unit;
    logic [u8dec_pkg::UNITS_PER_ITEM-1:0] v_last;
    logic [2:0] v_n;
    logic       v_tail;
    logic [7:0] v_hb [3];

    // room for one more unit plus the terminator
    function automatic logic room1(input logic [8:0] w, input logic [8:0] cap);
        return ({1'b0, w} + 10'd1) < {1'b0, cap};
    endfunction

    // room for a surrogate pair plus the terminator
    function automatic logic room2(input logic [8:0] w, input logic [8:0] cap);
        return ({1'b0, w} + 10'd2) < {1'b0, cap};
    endfunction

    assign o_in_stall = i_qstat.full;
    assign w_accept = i_in_valid && !i_qstat.full;

    // Byte classification
    assign w_zero = (i_in_byte == 8'd0);
    assign w_cont = ((i_in_byte & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG);
    assign w_lead = (i_in_byte >= u8dec_pkg::LEAD_MIN) && (i_in_byte <= u8dec_pkg::LEAD_MAX);
    assign w_need = (i_in_byte >= u8dec_pkg::LEAD4_MIN) ? 2'd3 :
                    (i_in_byte >= u8dec_pkg::LEAD3_MIN) ? 2'd2 : 2'd1;

    // Code point assembly from the held bytes and the final continuation
    assign w_lead_bits = r_hb0[5:0] & (6'h3F >> r_ne);
    always_comb begin
        case (r_hc)
            2'd1:    w_code = {9'd0, w_lead_bits, i_in_byte[5:0]};
            2'd2:    w_code = {3'd0, w_lead_bits, r_hb1[5:0], i_in_byte[5:0]};
            default: w_code = {w_lead_bits[2:0], r_hb1[5:0], r_hb2[5:0], i_in_byte[5:0]};
        endcase
    end
    assign w_cm = w_code - u8dec_pkg::SUPP_BASE;
    assign w_hi = u8dec_pkg::HI_SURR + {10'd0, w_cm[20:10]};
    assign w_lo = u8dec_pkg::LO_SURR + {11'd0, w_cm[9:0]};

    // Effective capacity of a config write: zero acts as one, large values saturate
    always_comb begin
        if (i_cfg_data == 9'd0) begin
            w_cap_eff = 9'd1;
        end else if ({1'b0, i_cfg_data} > 10'(u8dec_pkg::MAX_CAPACITY)) begin
            w_cap_eff = 9'(u8dec_pkg::MAX_CAPACITY);
        end else begin
            w_cap_eff = i_cfg_data;
        end
    end

    // Per-item decision: results in order, next state
    always_comb begin
        v_unit = '0;
        v_last = '0;
        v_n = 3'd0;
        v_tail = 1'b0;
        v_hb[0] = r_hb0;
        v_hb[1] = r_hb1;
        v_hb[2] = r_hb2;
        n_hb0 = r_hb0;
        n_hb1 = r_hb1;
        n_hb2 = r_hb2;
        n_hc = r_hc;
        n_ne = r_ne;
        n_w = r_w;
        n_full = r_full;

        if (r_full) begin
            // dropping until end of string
            if (w_zero) begin
                n_hc = 2'd0;
                n_ne = 2'd0;
                n_w = 9'd0;
                n_full = 1'b0;
            end
        end else if (!room1(r_w, r_cap)) begin
            // buffer reached its limit: terminator now
            n_hc = 2'd0;
            n_ne = 2'd0;
            v_unit[0] = '0;
            v_last[0] = 1'b1;
            v_n = 3'd1;
            if (w_zero) begin
                n_w = 9'd0;
            end else begin
                n_full = 1'b1;
            end
        end else if (r_hc != 2'd0 && w_cont) begin
            if (r_hc >= r_ne) begin
                // sequence complete
                n_hc = 2'd0;
                n_ne = 2'd0;
                if (r_mode && w_code > u8dec_pkg::BMP_MAX) begin
                    if (!room2(r_w, r_cap)) begin
                        // pair does not fit: close the string
                        v_unit[0] = '0;
                        v_last[0] = 1'b1;
                        v_n = 3'd1;
                        n_full = 1'b1;
                    end else begin
                        v_unit[0] = w_hi;
                        v_unit[1] = w_lo;
                        v_n = 3'd2;
                        n_w = r_w + 9'd2;
                    end
                end else begin
                    v_unit[0] = w_code;
                    v_n = 3'd1;
                    n_w = r_w + 9'd1;
                end
            end else begin
                // hold another continuation byte
                if (r_hc == 2'd1) begin
                    n_hb1 = i_in_byte;
                end else begin
                    n_hb2 = i_in_byte;
                end
                n_hc = r_hc + 2'd1;
            end
            v_tail = 1'b1;
        end else begin
            // replay a broken sequence as Latin-1
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < r_hc && room1(n_w, r_cap) && v_n < 3'd4) begin
                    v_unit[v_n[1:0]] = {13'd0, v_hb[k]};
                    v_n = v_n + 3'd1;
                    n_w = n_w + 9'd1;
                end
            end
            n_hc = 2'd0;
            n_ne = 2'd0;
            if (w_zero) begin
                if (v_n < 3'd4) begin
                    v_unit[v_n[1:0]] = '0;
                    v_last[v_n[1:0]] = 1'b1;
                    v_n = v_n + 3'd1;
                end
                n_w = 9'd0;
                n_full = 1'b0;
            end else begin
                if (w_lead) begin
                    n_hb0 = i_in_byte;
                    n_hc = 2'd1;
                    n_ne = w_need;
                end else if (room1(n_w, r_cap) && v_n < 3'd4) begin
                    v_unit[v_n[1:0]] = {13'd0, i_in_byte};
                    v_n = v_n + 3'd1;
                    n_w = n_w + 9'd1;
                end
                v_tail = 1'b1;
            end
        end

        // terminator in the same item if it fits in the bundle
        if (v_tail && !n_full && !room1(n_w, r_cap)) begin
            n_hc = 2'd0;
            n_ne = 2'd0;
            if (v_n < 3'd4) begin
                v_unit[v_n[1:0]] = '0;
                v_last[v_n[1:0]] = 1'b1;
                v_n = v_n + 3'd1;
                n_full = 1'b1;
            end
        end
    end

    assign o_push = w_accept && (v_n != 3'd0);
    assign o_entry.last_idx = 2'(v_n - 3'd1);
    assign o_entry.unit = v_unit;
    assign o_entry.last = v_last;

    // Held bytes carry no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hb0 <= n_hb0;
            r_hb1 <= n_hb1;
            r_hb2 <= n_hb2;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= u8dec_pkg::CAP_RESET;
            r_mode <= u8dec_pkg::MODE_RESET;
            r_hc <= 2'd0;
            r_ne <= 2'd0;
            r_w <= 9'd0;
            r_full <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    u8dec_pkg::REG_CAPACITY:         r_cap <= w_cap_eff;
                    u8dec_pkg::REG_SIXTEEN_BIT_MODE: r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_hc <= n_hc;
                r_ne <= n_ne;
                r_w <= n_w;
                r_full <= n_full;
            end
        end
    end

endmodule

// File: design/u8dec_queue.sv
// Small FIFO of result bundles between the front end and the output side.
// Uses u8dec_pkg for the entry type and depth.
module u8dec_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u8dec_pkg::t_entry  i_entry,
    input  logic               i_pop,
    output u8dec_pkg::t_qstat  o_qstat,
    output u8dec_pkg::t_entry  o_head
);

    u8dec_pkg::t_entry r_slots [u8dec_pkg::QDEPTH];
    logic [u8dec_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [u8dec_pkg::QCNT_W-1:0] r_count;

    logic w_push, w_pop;

    assign o_qstat.full = (r_count == u8dec_pkg::QCNT_W'(u8dec_pkg::QDEPTH));
    assign o_qstat.valid = (r_count != '0);
    assign o_head = r_slots[r_rd_ptr];

    assign w_push = i_push && !o_qstat.full;
    assign w_pop = i_pop && o_qstat.valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= u8dec_pkg::QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (w_pop) begin
                r_rd_ptr <= u8dec_pkg::QPTR_W'(r_rd_ptr + 1'b1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/u8dec_back.sv
// Output side: walks the units of the head bundle into a registered output,
// one unit per cycle unless the output stalls. Uses u8dec_pkg for the entry type.
module u8dec_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  u8dec_pkg::t_qstat             i_qstat,
    input  u8dec_pkg::t_entry             i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [u8dec_pkg::UNIT_W-1:0]  o_code_unit,
    output logic                          o_last
);

    logic [1:0] r_slot;
    logic       r_valid;
    logic [u8dec_pkg::UNIT_W-1:0] r_unit;
    logic       r_last;
    logic       w_load;

    // Output register free or emptying this cycle
    assign w_load = i_qstat.valid && (!r_valid || !i_out_stall);
    assign o_pop = w_load && (r_slot == i_head.last_idx);

    assign o_out_valid = r_valid;
    assign o_code_unit = r_unit;
    assign o_last = r_last;

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_unit <= i_head.unit[r_slot];
            r_last <= i_head.last[r_slot];
        end
    end

    // Valid flag and position within the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_slot <= o_pop ? 2'd0 : r_slot + 2'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// File: design/utf8_to_utf16_or_utf32_decoder_unit.sv
// UTF-8 to UTF-16/UTF-32 decoder with Latin-1 fallback: top level.
// Instantiates u8dec_front, u8dec_queue and u8dec_back; uses u8dec_pkg.
//
// One byte enters per cycle while the output is not stalled and each byte
// yields at most one output unit; a byte that yields more units (a surrogate
// pair, a replayed broken sequence, a terminator) sends them out one unit per
// cycle, and the four-bundle queue between the decoder front end and the
// output register absorbs such bursts, so input stalls only once that queue
// is full. The output side serializes one unit per cycle unless stalled,
// which bounds sustained throughput. Capacity writes of zero act as one,
// values above 256 act as 256; the user must make register writes only while
// the block is idle, and the block itself does not enforce this.
module utf8_to_utf16_or_utf32_decoder_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic [7:0]   i_in_byte,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [20:0]  o_code_unit,
    output logic         o_last,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [8:0]   i_cfg_data
);

    u8dec_pkg::t_qstat w_qstat;
    u8dec_pkg::t_entry w_entry, w_head;
    logic w_push, w_pop;

    // Decode and classify
    u8dec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_byte   (i_in_byte),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    // Bundle queue
    u8dec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_qstat (w_qstat),
        .o_head  (w_head)
    );

    // Unit serializer
    u8dec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (w_qstat),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_code_unit (o_code_unit),
        .o_last      (o_last)
    );

endmodule
